@@ rtl/gsls_pkg.sv @@
package gsls_pkg;

    localparam int MAX_POINTS_DEF     = 8192;
    localparam int EXP_TABLE_SIZE_DEF = 1024;

    localparam int POS_W   = 21;
    localparam int LIK_W   = 32;
    localparam int SIG_W   = 22;
    localparam int NORM_W  = 32;
    localparam int CNT_W   = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int W_W     = 17;   // ROM entry width (entry 0 is 65536)
    localparam int SUM_W   = 48;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE  = 2'd2;

    localparam logic [CNT_W-1:0]  RST_POINT_COUNT = 14'd6000;
    localparam logic [SIG_W-1:0]  RST_INV_SIGMA   = 22'd22216;
    localparam logic [NORM_W-1:0] RST_NORM_SCALE  = 32'd58097593;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear;    // start of a query: zero accumulator
        logic issue;    // read one entry and start it down the pipe
        logic finish;   // latch the clipped sum
    } gsls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;   // some entry still in flight
    } gsls_sts_t;

    // round(65536*exp(-k/32)), double-precision generation at elaboration
    function automatic logic [W_W-1:0] exp_entry(input int k);
        real v;
        v = 65536.0 * $exp(-real'(k) / 32.0);
        return W_W'($rtoi(v + 0.5));
    endfunction

endpackage

@@ rtl/gsls_ctrl.sv @@
module gsls_ctrl
    import gsls_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int IW = $clog2(MAX_POINTS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] point_count,
    input  gsls_sts_t        sts,
    input  logic             out_free,
    output logic             busy,
    output logic [IW-1:0]    rd_addr,
    output gsls_cmd_t        cmd
);

    typedef enum logic [1:0] { S_IDLE, S_RUN, S_DRAIN, S_DONE } state_t;

    localparam int NW = IW + 1;

    state_t         state_reg, state_next;
    logic [NW-1:0]  idx_reg, idx_next;
    logic [NW-1:0]  lim_reg, lim_next;
    logic [NW-1:0]  cnt_ext;

    // count is clamped to MAX_POINTS
    always_comb
    begin
        if (32'(point_count) > 32'(MAX_POINTS))
            cnt_ext = NW'(MAX_POINTS);
        else
            cnt_ext = NW'(point_count);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.clear  = 1'b1;
                    idx_next   = '0;
                    lim_next   = cnt_ext;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (idx_reg == lim_reg)
                    state_next = S_DRAIN;
                else
                begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy && out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            lim_reg   <= lim_next;
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = idx_reg[IW-1:0];

endmodule

@@ rtl/gsls_datapath.sv @@
module gsls_datapath
    import gsls_pkg::*;
#(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int EXP_TABLE_SIZE = EXP_TABLE_SIZE_DEF,
    localparam int IW = $clog2(MAX_POINTS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [IW-1:0]           wr_addr,
    input  logic [LIK_W-1:0]        wr_lik,
    input  logic signed [POS_W-1:0] wr_pos,
    input  logic signed [POS_W-1:0] query_position,
    input  logic [SIG_W-1:0]        inv_sigma,
    input  logic [NORM_W-1:0]       norm_scale,
    input  logic [IW-1:0]           rd_addr,
    input  gsls_cmd_t               cmd,
    output gsls_sts_t               sts,
    output logic [LIK_W-1:0]        sum_out,
    output logic                    sat_out
);

    localparam int XW = $clog2(EXP_TABLE_SIZE);

    logic [LIK_W-1:0] lik_mem [MAX_POINTS];
    logic [POS_W-1:0] pos_mem [MAX_POINTS];

    logic [LIK_W-1:0] s1_lik_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic [POS_W:0]   s2_ad_reg;
    logic [LIK_W-1:0] s2_lik_reg;
    logic [44:0]      s3_zq_reg;
    logic [LIK_W-1:0] s3_lik_reg;
    logic [59:0]      s4_sq_reg;
    logic             s4_big_reg;
    logic [LIK_W-1:0] s4_lik_reg;
    logic [W_W-1:0]   s5_w_reg;
    logic [LIK_W-1:0] s5_lik_reg;
    logic [32:0]      s6_a_reg;
    logic [32:0]      s7_t_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [6:0]       vld_reg;
    logic [LIK_W-1:0] sum_reg;
    logic             sat_reg;

    logic signed [POS_W:0] diff;
    logic [15:0]           idx_hi;
    logic [W_W-1:0]        w_next;
    logic [48:0]           a_full;
    logic [64:0]           t_full;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lik_mem[wr_addr] <= wr_lik;
            pos_mem[wr_addr] <= wr_pos;
        end
        s1_lik_reg <= lik_mem[rd_addr];
        s1_pos_reg <= pos_mem[rd_addr];
    end

    assign diff   = (POS_W+1)'(query_position) - (POS_W+1)'($signed(s1_pos_reg));
    assign idx_hi = s4_sq_reg[59:44];

    always_comb
    begin
        if (s4_big_reg || 32'(idx_hi) >= 32'(EXP_TABLE_SIZE))
            w_next = '0;
        else
            w_next = exp_entry(int'(idx_hi[XW-1:0]));
    end

    assign a_full = 49'(s5_lik_reg) * 49'(s5_w_reg);
    assign t_full = 65'(s6_a_reg) * 65'(norm_scale);

    // payload pipe: read, |d|, |d|*inv_sigma, square, ROM, *lik, *norm
    always_ff @(posedge clk)
    begin
        s2_ad_reg  <= diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
        s2_lik_reg <= s1_lik_reg;
        s3_zq_reg  <= 45'(s2_ad_reg) * 45'(inv_sigma);
        s3_lik_reg <= s2_lik_reg;
        s4_big_reg <= (s3_zq_reg[44:30] != '0);
        s4_sq_reg  <= 60'(s3_zq_reg[29:0]) * 60'(s3_zq_reg[29:0]);
        s4_lik_reg <= s3_lik_reg;
        s5_w_reg   <= w_next;
        s5_lik_reg <= s4_lik_reg;
        s6_a_reg   <= a_full[48:16];
        s7_t_reg   <= t_full[64:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            acc_reg <= '0;
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], cmd.issue};
            if (cmd.clear)
                acc_reg <= '0;
            else if (vld_reg[6])
                acc_reg <= acc_reg + SUM_W'(s7_t_reg);
            if (cmd.finish)
            begin
                if (acc_reg > SUM_W'(64'h8000_0000))
                begin
                    sum_reg <= 32'h8000_0000;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= acc_reg[LIK_W-1:0];
                    sat_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.pipe_busy = |vld_reg;
    assign sum_out = sum_reg;
    assign sat_out = sat_reg;

endmodule

@@ rtl/gaussian_smear_likelihood_sum.sv @@
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | op, point_index, point_likelihood, point_position,
//         |                      | query_position
// out     | out_valid/ out_ready | smeared_likelihood, saturated
// cfg     | cfg_we               | cfg_index, cfg_data
// Load items can be taken back to back. A query reads point_count (clamped to
// MAX_POINTS) store entries, one store read per cycle feeding a 7-stage weight
// and multiply pipe into one accumulator; the result is registered once the pipe
// has drained. Reset is asynchronous active low and restores the register
// defaults; the store is not cleared. in_ready is low during a query and while a
// result is held; the result waits in its register.
module gaussian_smear_likelihood_sum
    import gsls_pkg::*;
#(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int EXP_TABLE_SIZE = EXP_TABLE_SIZE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [12:0]             point_index,
    input  logic [LIK_W-1:0]        point_likelihood,
    input  logic signed [POS_W-1:0] point_position,
    input  logic signed [POS_W-1:0] query_position,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LIK_W-1:0]        smeared_likelihood,
    output logic                    saturated,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data
);

    localparam int IW = $clog2(MAX_POINTS);

    logic [CNT_W-1:0]        point_count_reg;
    logic [SIG_W-1:0]        inv_sigma_reg;
    logic [NORM_W-1:0]       norm_scale_reg;
    logic signed [POS_W-1:0] query_reg;
    logic                    out_valid_reg;

    logic      busy, start, accept, wr_en;
    logic [IW-1:0] rd_addr;
    gsls_cmd_t cmd;
    gsls_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= RST_POINT_COUNT;
            inv_sigma_reg   <= RST_INV_SIGMA;
            norm_scale_reg  <= RST_NORM_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT: point_count_reg <= cfg_data[CNT_W-1:0];
                REG_INV_SIGMA:   inv_sigma_reg   <= cfg_data[SIG_W-1:0];
                REG_NORM_SCALE:  norm_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = !busy && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign start    = accept && (op == OP_QUERY);
    // slots beyond the store are dropped
    assign wr_en    = accept && (op == OP_LOAD) && (32'(point_index) < 32'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (start)
            query_reg <= query_position;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    gsls_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .point_count (point_count_reg),
        .sts         (sts),
        .out_free    (!out_valid_reg),
        .busy        (busy),
        .rd_addr     (rd_addr),
        .cmd         (cmd)
    );

    gsls_datapath #(
        .MAX_POINTS     (MAX_POINTS),
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (IW'(point_index)),
        .wr_lik         (point_likelihood),
        .wr_pos         (point_position),
        .query_position (query_reg),
        .inv_sigma      (inv_sigma_reg),
        .norm_scale     (norm_scale_reg),
        .rd_addr        (rd_addr),
        .cmd            (cmd),
        .sts            (sts),
        .sum_out        (smeared_likelihood),
        .sat_out        (saturated)
    );

    assign out_valid = out_valid_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("item taken during query");
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (smeared_likelihood == 32'h8000_0000))
        else $error("saturated result not clipped");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !sts.pipe_busy) else $error("finish with pipe busy");

endmodule

@@ verif/gaussian_smear_likelihood_sum_tb.sv @@
module gaussian_smear_likelihood_sum_tb;
    import gsls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 8192;
    localparam int ROM_DEPTH   = 1024;
    localparam int WORK_SLOTS  = 32;   // slots filled early; queries stay below this

    typedef struct {
        logic [31:0] value;
        logic        clip;
    } smear_result_t;

    class smear_sum_predictor;
        logic [CNT_W-1:0]    count_reg;
        logic [SIG_W-1:0]    inv_sigma_reg;
        logic [NORM_W-1:0]   norm_reg;
        logic [31:0]         lik_mem [STORE_DEPTH];
        logic signed [20:0]  pos_mem [STORE_DEPTH];
        logic [16:0]         gauss_rom [ROM_DEPTH];
        smear_result_t       expected_sums [$];
        int                  mismatches;

        function new();
            for (int k = 0; k < ROM_DEPTH; k++)
                gauss_rom[k] = 17'($rtoi(65536.0 * $exp(-real'(k) / 32.0) + 0.5));
            count_reg     = RST_POINT_COUNT;
            inv_sigma_reg = RST_INV_SIGMA;
            norm_reg      = RST_NORM_SCALE;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_POINT_COUNT: count_reg     = data[CNT_W-1:0];
                REG_INV_SIGMA:   inv_sigma_reg = data[SIG_W-1:0];
                REG_NORM_SCALE:  norm_reg      = data;
                default: ;
            endcase
        endfunction

        function void note_item(logic kind, logic [12:0] slot, logic [31:0] lik,
                                logic signed [20:0] ppos, logic signed [20:0] qpos);
            logic signed [21:0] diff;
            logic [21:0]        mag;
            logic [63:0]        zq;
            logic [63:0]        ridx;
            logic [16:0]        wt;
            logic [63:0]        scaled;
            logic [95:0]        term;
            logic [63:0]        acc;
            int                 n;
            smear_result_t      r;
            if (kind == OP_LOAD) begin
                lik_mem[slot] = lik;
                pos_mem[slot] = ppos;
                return;
            end
            n = (count_reg > STORE_DEPTH) ? STORE_DEPTH : count_reg;
            acc = 0;
            for (int i = 0; i < n; i++) begin
                diff = qpos - pos_mem[i];
                mag  = (diff < 0) ? 22'(-diff) : 22'(diff);
                zq   = 64'(mag) * 64'(inv_sigma_reg);
                wt   = 0;
                if (zq < 64'd1 << 30) begin
                    ridx = (zq * zq) >> 44;
                    if (ridx < ROM_DEPTH)
                        wt = gauss_rom[ridx];
                end
                scaled = (64'(lik_mem[i]) * 64'(wt)) >> 16;
                term   = (96'(scaled) * 96'(norm_reg)) >> 32;
                acc    = acc + term[63:0];
            end
            if (acc > 64'd1 << 31) begin
                r.value = 32'h8000_0000;
                r.clip  = 1'b1;
            end else begin
                r.value = acc[31:0];
                r.clip  = 1'b0;
            end
            expected_sums.push_back(r);
        endfunction

        function void check_result(logic [31:0] value, logic clip);
            smear_result_t e;
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sum=%h sat=%b", value, clip);
                return;
            end
            e = expected_sums.pop_front();
            if (value !== e.value || clip !== e.clip) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp sum=%h sat=%b, got sum=%h sat=%b",
                             e.value, e.clip, value, clip);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic [12:0]        point_index;
    logic [31:0]        point_likelihood;
    logic signed [20:0] point_position;
    logic signed [20:0] query_position;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        smeared_likelihood;
    logic               saturated;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    smear_sum_predictor pred;
    bit  steady_tx;
    bit  steady_rx;
    int  hold_cycles;

    gaussian_smear_likelihood_sum dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                pred.check_result(smeared_likelihood, saturated);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady_rx ? 1'b1 : ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic logic signed [20:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? 21'sh0FFFFF : -21'sh100000;
        if (r == 1)
            return 21'($urandom());
        return 21'($signed($urandom_range(0, 8000)) - 4000);
    endfunction

    function automatic logic [31:0] pick_lik();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    task automatic send_item(logic kind, logic [12:0] slot, logic [31:0] lik,
                             logic signed [20:0] ppos, logic signed [20:0] qpos);
        if (!steady_tx && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        op               <= kind;
        point_index      <= slot;
        point_likelihood <= lik;
        point_position   <= ppos;
        query_position   <= qpos;
        in_valid         <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pred.note_item(kind, slot, lik, ppos, qpos);
    endtask

    task automatic send_load(logic [12:0] slot);
        send_item(OP_LOAD, slot, pick_lik(), pick_pos(), 21'($urandom()));
    endtask

    task automatic send_query(logic signed [20:0] qpos);
        send_item(OP_QUERY, 13'($urandom()), $urandom(), 21'($urandom()), qpos);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 1) != 0)
            send_query(pick_pos());
        else if ($urandom_range(0, 7) == 0)
            send_load(13'($urandom()));
        else
            send_load(13'($urandom_range(0, WORK_SLOTS - 1)));
    endtask

    // idle the input, drain every pending result, then allow the pipe to empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pred.expected_sums.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred.set_reg(idx, data);
    endtask

    task automatic set_phase(logic [31:0] cnt, logic [31:0] sig, logic [31:0] norm);
        settle();
        write_reg(REG_POINT_COUNT, cnt);
        write_reg(REG_INV_SIGMA, sig);
        write_reg(REG_NORM_SCALE, norm);
        write_reg(2'd3, $urandom());   // unused index, must be ignored
    endtask

    initial
    begin
        pred             = new();
        steady_tx        = 1'b0;
        steady_rx        = 1'b0;
        hold_cycles      = 0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        op               = OP_LOAD;
        point_index      = '0;
        point_likelihood = '0;
        point_position   = '0;
        query_position   = '0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count exceeds the written slots, so shrink it before any query
        write_reg(REG_POINT_COUNT, WORK_SLOTS);
        send_item(OP_LOAD, 13'd0, 32'h0, -21'sh100000, '0);
        send_item(OP_LOAD, 13'd1, 32'h8000_0000, 21'sh0FFFFF, '0);
        send_item(OP_LOAD, 13'd2, 32'hFFFF_FFFF, 21'sh0, '0);   // likelihood above 1.0
        send_item(OP_LOAD, 13'd3, 32'h8000_0000, 21'sh0, '0);
        for (int i = 4; i < WORK_SLOTS; i++)
            send_load(13'(i));

        send_query(-21'sh100000);
        send_query(21'sh0FFFFF);
        send_query(21'sh0);
        send_query(21'sh10);

        // zero width: every point at full weight, sum clips
        set_phase(4, 0, 32'hFFFF_FFFF);
        send_query(21'sh0);
        send_query(-21'sh100000);
        set_phase(0, 22216, 32'h8000_0000);   // empty sum
        send_query(21'sh0);
        set_phase(1, 22'h3FFFFF, 32'h0);
        send_query(21'sh0);
        send_query(21'sh1);

        // receiver holds off while the sender keeps offering items
        set_phase(WORK_SLOTS, 22216, 58097593);
        send_query(pick_pos());
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            random_item();

        set_phase(17, 22'h3FFFFF, 32'hFFFF_FFFF);
        steady_tx = 1'b1;
        steady_rx = 1'b1;
        for (int i = 0; i < 20; i++)
            random_item();
        steady_tx = 1'b0;
        steady_rx = 1'b0;

        set_phase($urandom_range(1, WORK_SLOTS), $urandom_range(1, 22'h3FFFFF),
                  $urandom());
        for (int i = 0; i < 20; i++)
            random_item();

        settle();
        if (pred.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gsls_pkg.sv
rtl/gsls_ctrl.sv
rtl/gsls_datapath.sv
rtl/gaussian_smear_likelihood_sum.sv
verif/gaussian_smear_likelihood_sum_tb.sv
